>>> design/pfe_pkg.sv
// Package for the Playfair pair encryptor.
// Holds letter codes, commands, coordinate types and square helpers.
// No dependencies.
package pfe_pkg;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] pos_t;
    typedef logic [2:0] coord_t;
    typedef logic [1:0] cmd_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
    } lane_coord_t;

    localparam cmd_t CMD_KEY    = 2'd0;
    localparam cmd_t CMD_FINISH = 2'd1;
    localparam cmd_t CMD_PAIR   = 2'd2;
    localparam cmd_t CMD_SINGLE = 2'd3;

    localparam letter_t LET_I = 5'd8;
    localparam letter_t LET_J = 5'd9;
    localparam letter_t LET_Z = 5'd25;

    localparam pos_t   SQ_CELLS = 5'd25;
    localparam int     ALPHA    = 26;
    localparam coord_t SQ_LAST  = 3'd4;

    function automatic letter_t clamp_letter(input letter_t c);
        return (c > LET_Z) ? LET_Z : c;
    endfunction

    function automatic letter_t fold_j(input letter_t c);
        return (c == LET_J) ? LET_I : c;
    endfunction

    // row and column of a square index, row-major, five per row
    function automatic lane_coord_t pos_coord(input pos_t p);
        lane_coord_t rc;
        rc = '0;
        priority if (p < 5'd5)
        begin
            rc.row = 3'd0;
            rc.col = p[2:0];
        end
        else if (p < 5'd10)
        begin
            rc.row = 3'd1;
            rc.col = 3'(p - 5'd5);
        end
        else if (p < 5'd15)
        begin
            rc.row = 3'd2;
            rc.col = 3'(p - 5'd10);
        end
        else if (p < 5'd20)
        begin
            rc.row = 3'd3;
            rc.col = 3'(p - 5'd15);
        end
        else if (p < 5'd25)
        begin
            rc.row = 3'd4;
            rc.col = 3'(p - 5'd20);
        end
        else
        begin
            rc.row = 3'd0;
            rc.col = 3'd0;
        end
        return rc;
    endfunction

    function automatic pos_t coord_idx(input lane_coord_t rc);
        pos_t r5;
        r5 = {2'b00, rc.row};
        return (r5 << 2) + r5 + {2'b00, rc.col};
    endfunction

    function automatic coord_t wrap_inc(input coord_t x);
        return (x == SQ_LAST) ? 3'd0 : 3'(x + 3'd1);
    endfunction

endpackage

>>> design/pfe_in_if.sv
// Input channel of the Playfair pair encryptor: valid/ready plus item fields.
// Depends on pfe_pkg.
interface pfe_in_if
    import pfe_pkg::*;
();
    logic    valid;
    logic    ready;
    cmd_t    cmd;
    letter_t letter_a;
    letter_t letter_b;

    modport source (output valid, output cmd, output letter_a, output letter_b, input ready);
    modport sink   (input valid, input cmd, input letter_a, input letter_b, output ready);
endinterface

>>> design/pfe_out_if.sv
// Result channel of the Playfair pair encryptor: valid/ready plus result fields.
// Depends on pfe_pkg.
interface pfe_out_if
    import pfe_pkg::*;
();
    logic    valid;
    logic    ready;
    letter_t cipher_a;
    letter_t cipher_b;
    logic    pair_valid;

    modport source (output valid, output cipher_a, output cipher_b, output pair_valid,
                    input ready);
    modport sink   (input valid, input cipher_a, input cipher_b, input pair_valid,
                    output ready);
endinterface

>>> design/pfe_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module pfe_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

>>> design/pfe_lane.sv
// One letter lane: folds the letter into a position-table address and
// splits the returned square index into row and column. Depends on pfe_pkg.
module pfe_lane
    import pfe_pkg::*;
(
    input  letter_t     letter,
    input  pos_t        pos,
    output letter_t     lookup,
    output lane_coord_t coord
);

    assign lookup = fold_j(clamp_letter(letter));
    assign coord  = pos_coord(pos);

endmodule

>>> design/pfe_merge.sv
// Merge stage: applies the same-row, same-column and rectangle rules to the
// two lane coordinates and gives the two cipher square indexes. Depends on pfe_pkg.
module pfe_merge
    import pfe_pkg::*;
(
    input  lane_coord_t coord_a,
    input  lane_coord_t coord_b,
    output pos_t        idx_a,
    output pos_t        idx_b
);

    lane_coord_t new_a;
    lane_coord_t new_b;

    always_comb
    begin
        new_a = coord_a;
        new_b = coord_b;
        priority if (coord_a.row == coord_b.row)
        begin
            new_a.col = wrap_inc(coord_a.col);
            new_b.col = wrap_inc(coord_b.col);
        end
        else if (coord_a.col == coord_b.col)
        begin
            new_a.row = wrap_inc(coord_a.row);
            new_b.row = wrap_inc(coord_b.row);
        end
        else
        begin
            new_a.col = coord_b.col;
            new_b.col = coord_a.col;
        end
    end

    assign idx_a = coord_idx(new_a);
    assign idx_b = coord_idx(new_b);

endmodule

>>> design/playfair_pair_encrypt.sv
// Playfair pair encryptor, top level. Depends on pfe_pkg, pfe_in_if, pfe_out_if,
// pfe_ram, pfe_lane, pfe_merge.
// One item at a time. Key letter: placed on accept. Finish: 26-letter fill walk.
// Pair: position RAM read, square RAM read, result hand-off;
// single letter: hand-off. Output register frees the input while a result waits.
// Reset clears used-letter flags, fill index, walk letter, state and output valid.
module playfair_pair_encrypt
    import pfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pfe_in_if.sink    plain,
    pfe_out_if.source cipher
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_SQR  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    pos_t             fill_reg, fill_next;
    letter_t          walk_reg, walk_next;
    logic [ALPHA-1:0] used_reg, used_next;

    letter_t res_a_reg, res_a_next;
    letter_t res_b_reg, res_b_next;
    logic    res_pair_reg, res_pair_next;

    logic    out_valid_reg, out_valid_next;
    letter_t out_a_reg, out_a_next;
    letter_t out_b_reg, out_b_next;
    logic    out_pair_reg, out_pair_next;

    logic        accept;
    logic        place_try;
    letter_t     place_raw;
    letter_t     place_c;
    logic        place_we;
    letter_t     lookup_a, lookup_b;
    pos_t        pos_a, pos_b;
    lane_coord_t coord_a, coord_b;
    pos_t        idx_a, idx_b;
    letter_t     sq_a, sq_b;

    assign plain.ready = (state_reg == ST_IDLE);
    assign accept      = plain.valid && plain.ready;

    // placement: a key letter in IDLE or the walk letter during the fill
    always_comb
    begin
        if (state_reg == ST_FILL)
        begin
            place_raw = walk_reg;
            place_try = (walk_reg != LET_J);
        end
        else
        begin
            place_raw = plain.letter_a;
            place_try = accept && (plain.cmd == CMD_KEY) && (plain.letter_a <= LET_Z);
        end
        place_c  = fold_j(place_raw);
        place_we = place_try && (place_c <= LET_Z) && !used_reg[place_c]
                   && (fill_reg < SQ_CELLS);
    end

    pfe_lane u_lane_a (
        .letter (plain.letter_a),
        .pos    (pos_a),
        .lookup (lookup_a),
        .coord  (coord_a)
    );

    pfe_lane u_lane_b (
        .letter (plain.letter_b),
        .pos    (pos_b),
        .lookup (lookup_b),
        .coord  (coord_b)
    );

    pfe_ram #(.WIDTH(5), .DEPTH(26)) u_pos_ram (
        .clk    (clk),
        .we     (place_we),
        .waddr  (place_c),
        .wdata  (fill_reg),
        .re     (accept && (plain.cmd == CMD_PAIR)),
        .raddr0 (lookup_a),
        .raddr1 (lookup_b),
        .rdata0 (pos_a),
        .rdata1 (pos_b)
    );

    pfe_merge u_merge (
        .coord_a (coord_a),
        .coord_b (coord_b),
        .idx_a   (idx_a),
        .idx_b   (idx_b)
    );

    pfe_ram #(.WIDTH(5), .DEPTH(25)) u_square_ram (
        .clk    (clk),
        .we     (place_we),
        .waddr  (fill_reg),
        .wdata  (place_c),
        .re     (state_reg == ST_LOOK),
        .raddr0 (idx_a),
        .raddr1 (idx_b),
        .rdata0 (sq_a),
        .rdata1 (sq_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        walk_next      = walk_reg;
        used_next      = used_reg;
        res_a_next     = res_a_reg;
        res_b_next     = res_b_reg;
        res_pair_next  = res_pair_reg;
        out_valid_next = out_valid_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_pair_next  = out_pair_reg;

        if (place_we)
        begin
            used_next[place_c] = 1'b1;
            fill_next          = 5'(fill_reg + 5'd1);
        end

        if (out_valid_reg && cipher.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (plain.cmd)
                        CMD_KEY:    state_next = ST_IDLE;
                        CMD_FINISH:
                        begin
                            walk_next  = '0;
                            state_next = ST_FILL;
                        end
                        CMD_PAIR:   state_next = ST_LOOK;
                        CMD_SINGLE:
                        begin
                            res_a_next    = clamp_letter(plain.letter_a);
                            res_b_next    = '0;
                            res_pair_next = 1'b0;
                            state_next    = ST_DONE;
                        end
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FILL:
            begin
                walk_next = 5'(walk_reg + 5'd1);
                if (walk_reg == LET_Z)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                res_a_next    = sq_a;
                res_b_next    = sq_b;
                res_pair_next = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || cipher.ready)
                begin
                    out_valid_next = 1'b1;
                    out_a_next     = res_a_reg;
                    out_b_next     = res_b_reg;
                    out_pair_next  = res_pair_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            walk_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            walk_reg      <= walk_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_a_reg    <= res_a_next;
        res_b_reg    <= res_b_next;
        res_pair_reg <= res_pair_next;
        out_a_reg    <= out_a_next;
        out_b_reg    <= out_b_next;
        out_pair_reg <= out_pair_next;
    end

    assign cipher.valid      = out_valid_reg;
    assign cipher.cipher_a   = out_a_reg;
    assign cipher.cipher_b   = out_b_reg;
    assign cipher.pair_valid = out_pair_reg;

endmodule
